// ===== hdl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue
// Entry layout, channel transactions, command and status codes, and the
// key ordering used by every storage cell.
// ----------------------------------------------------------------------------
package spq_pkg;

	// Sizing
	localparam int CAPACITY    = 256;
	localparam int WEIGHT_BITS = 32;
	localparam int SYMBOL_BITS = 8;
	localparam int HANDLE_BITS = 9;
	localparam int COUNT_BITS  = $clog2(CAPACITY + 1);

	// Command codes
	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	// Status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// One stored entry
	typedef struct packed {
		logic [WEIGHT_BITS-1:0] weight;
		logic [SYMBOL_BITS-1:0] symbol;
		logic [HANDLE_BITS-1:0] handle;
	} entry_t;

	// Command transaction
	typedef struct packed {
		logic                   command;
		logic [WEIGHT_BITS-1:0] weight_in;
		logic [SYMBOL_BITS-1:0] symbol_in;
		logic [HANDLE_BITS-1:0] handle_in;
	} spq_cmd_t;

	// Response transaction
	typedef struct packed {
		logic [WEIGHT_BITS-1:0] weight_out;
		logic [SYMBOL_BITS-1:0] symbol_out;
		logic [HANDLE_BITS-1:0] handle_out;
		logic [1:0]             status;
		logic                   is_empty;
		logic                   holds_one;
	} spq_rsp_t;

	// Update strobes broadcast to every cell
	typedef struct packed {
		logic enq;
		logic deq;
	} cell_ctl_t;

	// Key a orders strictly before key b: weight first, symbol breaks ties
	function automatic logic key_less(input entry_t a, input entry_t b);
		logic lt;
		lt = (a.weight < b.weight) || ((a.weight == b.weight) && (a.symbol < b.symbol));
		return lt;
	endfunction

endpackage

// ===== hdl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds one entry, compares it with the incoming key, and on each update
// keeps its entry, takes the new one, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell
	import spq_pkg::*;
(
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  entry_t    new_entry,
	input  entry_t    left_entry,
	input  entry_t    right_entry,
	input  logic      occupied,
	input  logic      left_ahead,
	output logic      ahead,
	output entry_t    entry
);

	entry_t entry_q;

	// New entry goes ahead of this slot when the slot is free or holds a larger key.
	// Equal keys stay ahead of the new entry.
	assign ahead = !occupied || key_less(new_entry, entry_q);
	assign entry = entry_q;

	// Insert: first slot with ahead set takes the new entry, later ones shift right.
	// Remove: every slot takes its right neighbor.
	always_ff @(posedge clk) begin
		if (ctl.enq) begin
			if (ahead && !left_ahead) begin
				entry_q <= new_entry;
			end else if (ahead) begin
				entry_q <= left_entry;
			end
		end else if (ctl.deq) begin
			entry_q <= right_entry;
		end
	end

endmodule

// ===== hdl/spq_out_stage.sv =====
// ----------------------------------------------------------------------------
// spq_out_stage: response register
// Holds one finished response until the receiver takes it and tells the
// command side when a new transaction can be taken.
// ----------------------------------------------------------------------------
module spq_out_stage
	import spq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     load,
	input  spq_rsp_t rsp_d,
	input  logic     rsp_stall,
	output logic     rsp_valid,
	output spq_rsp_t rsp,
	output logic     busy
);

	logic     valid_q;
	spq_rsp_t rsp_q;

	// Full and not drained this cycle: hold off the command side
	assign busy      = valid_q && rsp_stall;
	assign rsp_valid = valid_q;
	assign rsp       = rsp_q;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			valid_q <= 1'b0;
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

// ===== hdl/sorted_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_top: sorted minimum priority queue
// A row of storage cells kept in ascending key order; enqueue inserts in
// place, dequeue pops the head.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel (cmd_valid / cmd_stall / cmd) carries one enqueue or one
//   dequeue per transaction. Response channel (rsp_valid / rsp_stall / rsp)
//   returns exactly one response per command, in order.
//   Every cell compares its own entry with the incoming key in parallel and
//   shifts left or right with its neighbors, so each command updates the
//   store in the cycle it is accepted; its response is registered in the
//   single response register and shows in the cycle after. Throughput is
//   one command per cycle while the receiver keeps up.
//   When the receiver stalls, the finished response is held and cmd_stall
//   rises, so no further command is taken until the response is taken.
//   Reset empties the queue (entry count cleared) and drops any pending
//   response; cell contents are not cleared and are never read while free.
//   Dequeue on an empty queue reports ST_EMPTY, enqueue into a full queue
//   reports ST_FULL; neither changes the stored entries.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top
	import spq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_stall,
	input  spq_cmd_t cmd,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output spq_rsp_t rsp
);

	logic [COUNT_BITS-1:0] count_q;
	logic [COUNT_BITS-1:0] count_d;
	logic                  accept;
	logic                  is_full;
	logic                  is_empty_now;
	cell_ctl_t             ctl;
	entry_t                new_entry;
	spq_rsp_t              rsp_d;

	entry_t cell_entry [CAPACITY];
	logic   cell_ahead [CAPACITY];

	assign accept       = cmd_valid && !cmd_stall;
	assign is_full      = (count_q == COUNT_BITS'(CAPACITY));
	assign is_empty_now = (count_q == '0);

	assign new_entry.weight = cmd.weight_in;
	assign new_entry.symbol = cmd.symbol_in;
	assign new_entry.handle = cmd.handle_in;

	// Update strobes: only commands that change the store
	assign ctl.enq = accept && (cmd.command == CMD_ENQ) && !is_full;
	assign ctl.deq = accept && (cmd.command == CMD_DEQ) && !is_empty_now;

	// Cell row
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [COUNT_BITS-1:0] IDX = COUNT_BITS'(i);
		entry_t left_e;
		entry_t right_e;
		logic   left_b;

		if (i == 0) begin : g_head
			assign left_e = new_entry;
			assign left_b = 1'b0;
		end else begin : g_mid
			assign left_e = cell_entry[i-1];
			assign left_b = cell_ahead[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_e = cell_entry[i];
		end else begin : g_body
			assign right_e = cell_entry[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.new_entry   (new_entry),
			.left_entry  (left_e),
			.right_entry (right_e),
			.occupied    (IDX < count_q),
			.left_ahead  (left_b),
			.ahead       (cell_ahead[i]),
			.entry       (cell_entry[i])
		);
	end

	// Next entry count
	always_comb begin
		count_d = count_q;
		priority if (ctl.enq) begin
			count_d = count_q + COUNT_BITS'(1);
		end else if (ctl.deq) begin
			count_d = count_q - COUNT_BITS'(1);
		end
	end

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	// Response for the accepted command
	always_comb begin
		rsp_d            = '0;
		rsp_d.status     = ST_OK;
		rsp_d.is_empty   = (count_d == '0);
		rsp_d.holds_one  = (count_d == COUNT_BITS'(1));
		if (ctl.deq) begin
			rsp_d.weight_out = cell_entry[0].weight;
			rsp_d.symbol_out = cell_entry[0].symbol;
			rsp_d.handle_out = cell_entry[0].handle;
		end
		if (cmd.command == CMD_DEQ && is_empty_now) begin
			rsp_d.status = ST_EMPTY;
		end else if (cmd.command == CMD_ENQ && is_full) begin
			rsp_d.status = ST_FULL;
		end
	end

	spq_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.rsp_d     (rsp_d),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.busy      (cmd_stall)
	);

	// Checks
	logic head_ordered;
	assign head_ordered = !key_less(cell_entry[1], cell_entry[0]);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_BITS'(CAPACITY))
		else $error("entry count above capacity");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= COUNT_BITS'(2)) |-> head_ordered)
		else $error("head entries out of order");

	a_empty_deq: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.command == CMD_DEQ && is_empty_now)
		|=> (rsp_valid && rsp.status == ST_EMPTY && count_q == '0))
		else $error("dequeue while empty not reported");

	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.command == CMD_ENQ && !is_full)
		|=> (count_q == $past(count_q) + COUNT_BITS'(1)))
		else $error("enqueue did not grow the queue");

endmodule

// ===== tb/spq_order_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_order_checker: response predictor and comparator for the priority queue
// Watches both channels of the sorted priority queue. Keeps its own sorted
// copy of the queue, works out the response of every accepted command and
// compares each accepted response with the oldest one still due.
// ----------------------------------------------------------------------------
module spq_order_checker
	import spq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  logic        cmd_stall,
	input  spq_cmd_t    cmd,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  spq_rsp_t    rsp,
	output int unsigned failures,
	output int unsigned responses_due,
	output int unsigned enqueues_taken,
	output int unsigned entries_returned,
	output int unsigned empty_reports,
	output int unsigned full_reports,
	output int unsigned peak_fill
);

	// Shadow of the queue contents, head first
	entry_t   sorted_entries[$];
	// Responses still owed by the block, oldest first
	spq_rsp_t due_responses[$];
	spq_rsp_t predicted;
	spq_rsp_t oldest_due;

	initial begin
		failures         = 0;
		responses_due    = 0;
		enqueues_taken   = 0;
		entries_returned = 0;
		empty_reports    = 0;
		full_reports     = 0;
		peak_fill        = 0;
	end

	// Strict key order: lighter weight first, smaller symbol on a weight tie
	function automatic bit goes_ahead(input entry_t a, input entry_t b);
		if (a.weight != b.weight)
			return a.weight < b.weight;
		return a.symbol < b.symbol;
	endfunction

	// Apply one command to the shadow queue and return its response
	function automatic spq_rsp_t predict_response(input spq_cmd_t c);
		spq_rsp_t r;
		entry_t   e;
		int       pos;
		r = '0;
		r.status = ST_OK;
		if (c.command == CMD_ENQ) begin
			if (sorted_entries.size() >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				e.weight = c.weight_in;
				e.symbol = c.symbol_in;
				e.handle = c.handle_in;
				// equal keys keep arrival order: skip past them
				pos = 0;
				while (pos < sorted_entries.size() && !goes_ahead(e, sorted_entries[pos]))
					pos++;
				sorted_entries.insert(pos, e);
			end
		end else if (sorted_entries.size() == 0) begin
			r.status = ST_EMPTY;
		end else begin
			e = sorted_entries.pop_front();
			r.weight_out = e.weight;
			r.symbol_out = e.symbol;
			r.handle_out = e.handle;
		end
		r.is_empty  = (sorted_entries.size() == 0);
		r.holds_one = (sorted_entries.size() == 1);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [WEIGHT_BITS-1:0] want,
			input logic [WEIGHT_BITS-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			failures++;
		end
	endtask

	// Predict on every accepted command, compare on every accepted response
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sorted_entries.delete();
			due_responses.delete();
			responses_due = 0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				predicted = predict_response(cmd);
				due_responses.push_back(predicted);
				case (predicted.status)
					ST_EMPTY: empty_reports++;
					ST_FULL:  full_reports++;
					default: begin
						if (cmd.command == CMD_ENQ)
							enqueues_taken++;
						else
							entries_returned++;
					end
				endcase
				if (sorted_entries.size() > peak_fill)
					peak_fill = sorted_entries.size();
			end
			if (rsp_valid && !rsp_stall) begin
				if (due_responses.size() == 0) begin
					$display("%0t: response with nothing due, actual %p", $time, rsp);
					failures++;
				end else begin
					oldest_due = due_responses.pop_front();
					check_field("weight_out", oldest_due.weight_out, rsp.weight_out);
					check_field("symbol_out", WEIGHT_BITS'(oldest_due.symbol_out),
						WEIGHT_BITS'(rsp.symbol_out));
					check_field("handle_out", WEIGHT_BITS'(oldest_due.handle_out),
						WEIGHT_BITS'(rsp.handle_out));
					check_field("status", WEIGHT_BITS'(oldest_due.status),
						WEIGHT_BITS'(rsp.status));
					check_field("is_empty", WEIGHT_BITS'(oldest_due.is_empty),
						WEIGHT_BITS'(rsp.is_empty));
					check_field("holds_one", WEIGHT_BITS'(oldest_due.holds_one),
						WEIGHT_BITS'(rsp.holds_one));
				end
			end
			responses_due = due_responses.size();
		end
	end

endmodule

// ===== tb/tb_sorted_priority_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue_top: testbench for the sorted priority queue
// Drives enqueue and dequeue commands with random gaps and random response
// stalls, filling the queue past full and draining it past empty, while the
// checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue_top;
	import spq_pkg::*;

	localparam int unsigned TOTAL_ITEMS = 1820;
	localparam int unsigned LONG_HOLD   = 300;
	localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = '1;

	logic     clk;
	logic     arst_n;
	logic     cmd_valid;
	logic     cmd_stall;
	spq_cmd_t cmd;
	logic     rsp_valid;
	logic     rsp_stall;
	spq_rsp_t rsp;

	int unsigned failures;
	int unsigned responses_due;
	int unsigned enqueues_taken;
	int unsigned entries_returned;
	int unsigned empty_reports;
	int unsigned full_reports;
	int unsigned peak_fill;

	int unsigned items_sent;
	bit          quiet;
	bit          hold_request;
	bit          hold_started;

	sorted_priority_queue_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	spq_order_checker checker_i (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd_valid        (cmd_valid),
		.cmd_stall        (cmd_stall),
		.cmd              (cmd),
		.rsp_valid        (rsp_valid),
		.rsp_stall        (rsp_stall),
		.rsp              (rsp),
		.failures         (failures),
		.responses_due    (responses_due),
		.enqueues_taken   (enqueues_taken),
		.entries_returned (entries_returned),
		.empty_reports    (empty_reports),
		.full_reports     (full_reports),
		.peak_fill        (peak_fill)
	);

	// Clock and reset
	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Run limit
	initial begin
		#10_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// Idle length: mostly none or short, now and then long
	function automatic int unsigned idle_cycles();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Weights cluster on few values so ties are common
	function automatic logic [WEIGHT_BITS-1:0] pick_weight();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return $urandom_range(0, 7);
		if (r < 60)
			return $urandom_range(0, 255);
		if (r < 85)
			return $urandom;
		if (r < 92)
			return '0;
		return WEIGHT_MAX - $urandom_range(0, 1);
	endfunction

	function automatic logic [SYMBOL_BITS-1:0] pick_symbol();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return SYMBOL_BITS'($urandom_range(0, 3));
		if (r < 80)
			return SYMBOL_BITS'($urandom_range(0, 255));
		return (r < 90) ? 8'd0 : 8'd255;
	endfunction

	function automatic spq_cmd_t random_command(input int unsigned enq_pct);
		spq_cmd_t c;
		c.command   = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
		c.weight_in = pick_weight();
		c.symbol_in = pick_symbol();
		c.handle_in = HANDLE_BITS'($urandom_range(0, (1 << HANDLE_BITS) - 1));
		return c;
	endfunction

	// Offer one transaction and hold it until accepted, then idle a while
	task automatic send_command(input spq_cmd_t c);
		int unsigned gap;
		gap = idle_cycles();
		@(negedge clk);
		cmd_valid <= 1'b1;
		cmd       <= c;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		items_sent++;
		if (gap != 0) begin
			@(negedge clk);
			cmd_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_entry(input logic [WEIGHT_BITS-1:0] w, input logic [SYMBOL_BITS-1:0] s,
			input logic [HANDLE_BITS-1:0] h);
		spq_cmd_t c;
		c.command   = CMD_ENQ;
		c.weight_in = w;
		c.symbol_in = s;
		c.handle_in = h;
		send_command(c);
	endtask

	task automatic send_dequeue();
		spq_cmd_t c;
		c = random_command(0);
		send_command(c);
	endtask

	task automatic run_phase(input int unsigned enq_pct, input int unsigned length);
		repeat (length) send_command(random_command(enq_pct));
	endtask

	// Sender goes quiet until every response has come back
	task automatic drain_responses();
		@(negedge clk);
		cmd_valid <= 1'b0;
		wait (responses_due == 0);
	endtask

	// Response side: random stall runs, free runs, and one long hold-off
	initial begin : receiver
		int unsigned run_len;
		bit          run_stall;
		rsp_stall = 1'b0;
		run_len   = 0;
		run_stall = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_request && !hold_started) begin
				hold_started = 1'b1;
				run_stall    = 1'b1;
				run_len      = LONG_HOLD;
			end else if (run_len == 0) begin
				if (quiet || $urandom_range(0, 1) == 0) begin
					run_stall = 1'b0;
					run_len   = $urandom_range(1, 20);
				end else begin
					run_stall = 1'b1;
					run_len   = idle_cycles() + 1;
				end
			end
			rsp_stall <= run_stall;
			run_len = run_len - 1;
		end
	end

	// Stimulus and verdict
	initial begin : stimulus
		int unsigned mode;
		int unsigned enq_pct;
		int unsigned burst;
		cmd_valid    = 1'b0;
		cmd          = '0;
		items_sent   = 0;
		quiet        = 1'b0;
		hold_request = 1'b0;
		hold_started = 1'b0;
		wait (arst_n);

		// Directed: empty pop, key extremes, ties on weight and on full key
		send_dequeue();
		send_entry(32'd5, 8'd3, 9'd1);
		send_entry(32'd5, 8'd3, 9'd2);
		send_entry(32'd5, 8'd2, 9'd3);
		send_entry('0, 8'd255, 9'd511);
		send_entry(WEIGHT_MAX, 8'd0, 9'd0);
		send_entry(WEIGHT_MAX, 8'd255, 9'h155);
		send_entry(32'd5, 8'd3, 9'd4);
		repeat (7) send_dequeue();
		send_dequeue();
		send_entry(32'hA5A5_5A5A, 8'h5A, 9'h0AA);
		send_dequeue();
		send_entry(32'd1, 8'd0, 9'd7);
		send_entry(32'd1, 8'd0, 9'd8);
		send_dequeue();
		send_dequeue();
		drain_responses();

		// Fill past full, stall the receiver long, then drain past empty
		run_phase(100, CAPACITY + 6);
		quiet        = 1'b1;
		hold_request = 1'b1;
		run_phase(50, 40);
		quiet = 1'b0;
		run_phase(0, CAPACITY + 6);

		// Random phases biased toward filling, draining or churning
		while (items_sent < TOTAL_ITEMS) begin
			mode    = $urandom_range(0, 2);
			enq_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
			quiet   = ($urandom_range(0, 3) == 0);
			burst   = $urandom_range(20, 200);
			if (burst > TOTAL_ITEMS - items_sent)
				burst = TOTAL_ITEMS - items_sent;
			run_phase(enq_pct, burst);
			if ($urandom_range(0, 3) == 0)
				drain_responses();
		end
		quiet = 1'b0;
		drain_responses();
		repeat (4) @(posedge clk);

		$display("Covered %0d commands: %0d entries queued, %0d returned, peak fill %0d of %0d.",
			items_sent, enqueues_taken, entries_returned, peak_fill, CAPACITY);
		$display("Error paths: %0d pops while empty, %0d pushes while full.",
			empty_reports, full_reports);
		if (failures == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
